### hw/rtl/mlpq_pkg.sv
// shared types, command and status codes for the multi-lane priority queue
package mlpq_pkg;

    localparam logic [1:0] CMD_ENQ    = 2'd0;
    localparam logic [1:0] CMD_SERVE  = 2'd1;
    localparam logic [1:0] CMD_TOGGLE = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LANE = 3'd1;
    localparam logic [2:0] ST_CLOSED   = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_LAST     = 3'd5;

    localparam int ENTRY_W    = 26;
    localparam int LANE_IDX_W = 3;
    localparam int LEN_MAX_W  = 7;
    localparam logic [4:0] CNT_MAX = 5'd31;

    typedef struct packed {
        logic [15:0] tag;
        logic [1:0]  prio;
        logic [7:0]  items;
    } entry_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  lane;
        logic [1:0]  priority_req;
        logic [15:0] tag;
        logic [7:0]  item_count;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] served_tag;
        logic [1:0]  served_priority;
        logic [7:0]  served_items;
        logic        lane_now_open;
        logic [4:0]  moved_count;
        logic [4:0]  dropped_count;
    } out_word_t;

    typedef struct packed {
        logic                  found;
        logic [LANE_IDX_W-1:0] lane;
        logic [LEN_MAX_W-1:0]  len;
    } pick_t;

endpackage

### hw/rtl/mlpq_ram.sv
// generic single write, single read ram with registered read data
module mlpq_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### hw/rtl/mlpq_pick.sv
// shortest open lane finder, ties to the lowest index
module mlpq_pick #(
    parameter int LANES = 4,
    parameter int LW    = 5
) (
    input  logic [LANES-1:0]    lane_open,
    input  logic [LANES*LW-1:0] lens,
    output mlpq_pkg::pick_t     pick
);
    import mlpq_pkg::*;

    localparam int LNW = $clog2(LANES);

    logic           found;
    logic [LNW-1:0] best_lane;
    logic [LW-1:0]  best_len;

    always_comb begin
        found     = 1'b0;
        best_lane = '0;
        best_len  = '0;
        for (int i = 0; i < LANES; i++) begin
            if (lane_open[i] && (!found || lens[i*LW +: LW] < best_len)) begin
                found     = 1'b1;
                best_lane = LNW'(i);
                best_len  = lens[i*LW +: LW];
            end
        end
        pick.found = found;
        pick.lane  = LANE_IDX_W'(best_lane);
        pick.len   = LEN_MAX_W'(best_len);
    end
endmodule

### hw/rtl/multi_lane_priority_queue_rebalance_unit.sv
// top level: multi-lane priority queue with rebalance on lane close
// usage
//   s_ channel takes one command word (enqueue, serve, toggle lane); m_ channel
//   returns exactly one result word per command, in command order
//   entries live in one ram of LANES*QUEUE_DEPTH words, each lane a sorted
//   slice; all work goes through its single read and single write port
//   enqueue walks from the tail toward the head, moving each less urgent entry
//   back one place with a read and a write until the new word lands; serve
//   reads the head, then moves each later entry forward one place; close of a
//   lane reads its entries in order and inserts each into the shortest open
//   lane, or drops it when every open lane is full
//   one command at a time; s_ready is high only in idle with the output
//   register free or being taken this cycle
//   reset: all lanes open and empty, no result pending; the ram is not
//   cleared, since only entries below a lane's length are ever read
//   receiver stall: the result word holds in m_word with m_valid high and
//   the next command waits until it is taken
module multi_lane_priority_queue_rebalance_unit #(
    parameter int LANES       = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mlpq_pkg::in_word_t   s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mlpq_pkg::out_word_t  m_word
);
    import mlpq_pkg::*;

    localparam int LNW   = $clog2(LANES);
    localparam int LW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH = LANES * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [LW-1:0] FULL_LEN = LW'(QUEUE_DEPTH);

    // sequencer states, one-hot
    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_DECODE   = 11'b00000000010,
        S_INS_RD   = 11'b00000000100,
        S_INS_CMP  = 11'b00000001000,
        S_SRV_HEAD = 11'b00000010000,
        S_SHF_RD   = 11'b00000100000,
        S_SHF_WR   = 11'b00001000000,
        S_CLS_RD   = 11'b00010000000,
        S_CLS_PICK = 11'b00100000000,
        S_DONE     = 11'b01000000000,
        S_SPARE    = 11'b10000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [2:0]       lane_reg, lane_next;
    entry_t           entry_reg, entry_next;
    entry_t           served_reg, served_next;
    logic [LNW-1:0]   tgt_reg, tgt_next;
    logic [LW-1:0]    idx_reg, idx_next;
    logic [LW-1:0]    k_reg, k_next;
    logic [LW-1:0]    n_reg, n_next;
    logic             close_reg, close_next;
    logic [2:0]       status_reg, status_next;
    logic [4:0]       moved_reg, moved_next;
    logic [4:0]       dropped_reg, dropped_next;
    logic [LANES-1:0] open_reg, open_next;
    logic [LW-1:0]    len_reg [LANES];
    logic [LW-1:0]    len_next [LANES];
    out_word_t        out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    // ram port
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data;
    logic [ENTRY_W-1:0] rd_raw;
    entry_t        rd_entry;

    // shortest lane search
    logic [LANES*LW-1:0] len_flat;
    pick_t               pick;
    logic [LNW-1:0]      best_lane;
    logic [LW-1:0]       best_len;

    logic           lane_ok;
    logic [LNW-1:0] lane_idx;

    function automatic logic [AW-1:0] addr_of(input logic [LNW-1:0] ln,
                                              input logic [LW-1:0] idx);
        return AW'(ln) * AW'(QUEUE_DEPTH) + AW'(idx);
    endfunction

    function automatic logic [4:0] sat_inc(input logic [4:0] v);
        return (v == CNT_MAX) ? v : v + 5'd1;
    endfunction

    mlpq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_raw)
    );

    assign rd_entry = entry_t'(rd_raw);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            len_flat[i*LW +: LW] = len_reg[i];
        end
    end

    mlpq_pick #(
        .LANES(LANES),
        .LW   (LW)
    ) u_pick (
        .lane_open(open_reg),
        .lens     (len_flat),
        .pick     (pick)
    );

    assign best_lane = pick.lane[LNW-1:0];
    assign best_len  = pick.len[LW-1:0];

    assign lane_ok  = (32'(lane_reg) < LANES);
    assign lane_idx = lane_reg[LNW-1:0];

    // idle, and the output register is free or emptying now
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        lane_next    = lane_reg;
        entry_next   = entry_reg;
        served_next  = served_reg;
        tgt_next     = tgt_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        close_next   = close_reg;
        status_next  = status_reg;
        moved_next   = moved_reg;
        dropped_next = dropped_reg;
        open_next    = open_reg;
        len_next     = len_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd_next         = s_word.cmd;
                    lane_next        = s_word.lane;
                    entry_next.tag   = s_word.tag;
                    entry_next.prio  = s_word.priority_req;
                    entry_next.items = s_word.item_count;
                    served_next      = '0;
                    status_next      = ST_OK;
                    moved_next       = '0;
                    dropped_next     = '0;
                    close_next       = 1'b0;
                    state_next       = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                if (!lane_ok) begin
                    status_next = ST_BAD_LANE;
                end else begin
                    case (cmd_reg)
                        CMD_ENQ: begin
                            if (!open_reg[lane_idx]) begin
                                status_next = ST_CLOSED;
                            end else if (len_reg[lane_idx] == FULL_LEN) begin
                                status_next = ST_FULL;
                            end else begin
                                tgt_next   = lane_idx;
                                idx_next   = len_reg[lane_idx];
                                state_next = S_INS_RD;
                            end
                        end
                        CMD_SERVE: begin
                            if (!open_reg[lane_idx]) begin
                                status_next = ST_CLOSED;
                            end else if (len_reg[lane_idx] == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                // fetch the head, shift the rest afterwards
                                rd_en      = 1'b1;
                                rd_addr    = addr_of(lane_idx, '0);
                                n_next     = len_reg[lane_idx];
                                state_next = S_SRV_HEAD;
                            end
                        end
                        CMD_TOGGLE: begin
                            if (!open_reg[lane_idx]) begin
                                open_next[lane_idx] = 1'b1;
                            end else if ($countones(open_reg) <= 1) begin
                                status_next = ST_LAST;
                            end else begin
                                // close first so the lane drops out of the search
                                open_next[lane_idx] = 1'b0;
                                len_next[lane_idx]  = '0;
                                n_next              = len_reg[lane_idx];
                                k_next              = '0;
                                close_next          = 1'b1;
                                state_next          = S_CLS_RD;
                            end
                        end
                        default: begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (idx_reg == '0) begin
                    wr_en             = 1'b1;
                    wr_addr           = addr_of(tgt_reg, '0);
                    wr_data           = entry_reg;
                    len_next[tgt_reg] = len_reg[tgt_reg] + LW'(1);
                    if (close_reg) begin
                        moved_next = sat_inc(moved_reg);
                        state_next = S_CLS_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(tgt_reg, idx_reg - LW'(1));
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = addr_of(tgt_reg, idx_reg);
                if (rd_entry.prio > entry_reg.prio) begin
                    // less urgent neighbor moves back one place
                    wr_data    = rd_entry;
                    idx_next   = idx_reg - LW'(1);
                    state_next = S_INS_RD;
                end else begin
                    wr_data           = entry_reg;
                    len_next[tgt_reg] = len_reg[tgt_reg] + LW'(1);
                    if (close_reg) begin
                        moved_next = sat_inc(moved_reg);
                        state_next = S_CLS_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SRV_HEAD: begin
                served_next        = rd_entry;
                len_next[lane_idx] = len_reg[lane_idx] - LW'(1);
                idx_next           = LW'(1);
                state_next         = S_SHF_RD;
            end
            S_SHF_RD: begin
                if (idx_reg >= n_reg) begin
                    state_next = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(lane_idx, idx_reg);
                    state_next = S_SHF_WR;
                end
            end
            S_SHF_WR: begin
                wr_en      = 1'b1;
                wr_addr    = addr_of(lane_idx, idx_reg - LW'(1));
                wr_data    = rd_entry;
                idx_next   = idx_reg + LW'(1);
                state_next = S_SHF_RD;
            end
            S_CLS_RD: begin
                if (k_reg == n_reg) begin
                    state_next = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(lane_idx, k_reg);
                    state_next = S_CLS_PICK;
                end
            end
            S_CLS_PICK: begin
                entry_next = rd_entry;
                k_next     = k_reg + LW'(1);
                if (!pick.found || best_len == FULL_LEN) begin
                    // every open queue is full
                    dropped_next = sat_inc(dropped_reg);
                    state_next   = S_CLS_RD;
                end else begin
                    tgt_next   = best_lane;
                    idx_next   = best_len;
                    state_next = S_INS_RD;
                end
            end
            S_DONE: begin
                out_next.status          = status_reg;
                out_next.served_tag      = served_reg.tag;
                out_next.served_priority = served_reg.prio;
                out_next.served_items    = served_reg.items;
                out_next.lane_now_open   = lane_ok && open_reg[lane_idx];
                out_next.moved_count     = moved_reg;
                out_next.dropped_count   = dropped_reg;
                m_valid_next             = 1'b1;
                state_next               = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            open_reg    <= '1;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            open_reg    <= open_next;
            m_valid_reg <= m_valid_next;
            len_reg     <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        lane_reg    <= lane_next;
        entry_reg   <= entry_next;
        served_reg  <= served_next;
        tgt_reg     <= tgt_next;
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        n_reg       <= n_next;
        close_reg   <= close_next;
        status_reg  <= status_next;
        moved_reg   <= moved_next;
        dropped_reg <= dropped_next;
        out_reg     <= out_next;
    end

    // a result word only appears right after the finishing state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside the finishing state");

    // closing must never leave the block without an open lane
    a_one_lane_open: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg != '0)
        else $error("no lane left open");

    generate
        for (genvar g = 0; g < LANES; g++) begin : g_lane_chk
            // a closed lane holds nothing, and no lane overflows
            a_closed_empty: assert property (@(posedge aclk) disable iff (!aresetn)
                !open_reg[g] |-> (len_reg[g] == '0))
                else $error("closed lane still holds entries");
            a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
                len_reg[g] <= FULL_LEN)
                else $error("lane length beyond queue depth");
        end
    endgenerate

endmodule

### tb/mlpq_checker.sv
// result checker: mirrors the lane queues and compares every result word in order
module mlpq_checker #(
    parameter int LANES       = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  mlpq_pkg::in_word_t  s_word,
    input  logic                m_valid,
    input  logic                m_ready,
    input  mlpq_pkg::out_word_t m_word,
    output int                  fail_count,
    output int                  pending,
    output int                  result_count,
    output int                  drop_events
);
    timeunit 1ns;
    timeprecision 1ps;
    import mlpq_pkg::*;

    logic   open_q [LANES];
    int     len_q  [LANES];
    entry_t slot_q [LANES][QUEUE_DEPTH];
    out_word_t want_q[$];

    assign pending = want_q.size();

    function automatic bit place_entry(int ln, entry_t e);
        int pos;
        if (len_q[ln] >= QUEUE_DEPTH) return 0;
        pos = 0;
        while (pos < len_q[ln] && slot_q[ln][pos].prio <= e.prio) pos++;
        for (int i = len_q[ln]; i > pos; i--) slot_q[ln][i] = slot_q[ln][i-1];
        slot_q[ln][pos] = e;
        len_q[ln]++;
        return 1;
    endfunction

    function automatic out_word_t lane_outcome(in_word_t w);
        out_word_t r;
        int ln, opens, n, best, moved, dropped;
        entry_t e;
        entry_t old [QUEUE_DEPTH];
        r = '0;
        ln = w.lane;
        moved = 0;
        dropped = 0;
        if (ln >= LANES) begin
            r.status = ST_BAD_LANE;
        end else if (w.cmd == CMD_ENQ) begin
            e.tag = w.tag;
            e.prio = w.priority_req;
            e.items = w.item_count;
            if (!open_q[ln]) r.status = ST_CLOSED;
            else if (!place_entry(ln, e)) r.status = ST_FULL;
        end else if (w.cmd == CMD_SERVE) begin
            if (!open_q[ln]) begin
                r.status = ST_CLOSED;
            end else if (len_q[ln] == 0) begin
                r.status = ST_EMPTY;
            end else begin
                e = slot_q[ln][0];
                for (int i = 1; i < len_q[ln]; i++) slot_q[ln][i-1] = slot_q[ln][i];
                len_q[ln]--;
                r.served_tag = e.tag;
                r.served_priority = e.prio;
                r.served_items = e.items;
            end
        end else if (w.cmd == CMD_TOGGLE) begin
            if (!open_q[ln]) begin
                open_q[ln] = 1'b1;
            end else begin
                opens = 0;
                for (int i = 0; i < LANES; i++) if (open_q[i]) opens++;
                if (opens <= 1) begin
                    r.status = ST_LAST;
                end else begin
                    n = len_q[ln];
                    for (int k = 0; k < n; k++) old[k] = slot_q[ln][k];
                    open_q[ln] = 1'b0;
                    len_q[ln] = 0;
                    for (int k = 0; k < n; k++) begin
                        // shortest open lane, lowest index on ties
                        best = -1;
                        for (int i = 0; i < LANES; i++)
                            if (open_q[i] && (best < 0 || len_q[i] < len_q[best])) best = i;
                        if (best >= 0 && place_entry(best, old[k])) moved++;
                        else dropped++;
                    end
                end
            end
        end
        if (ln < LANES) r.lane_now_open = open_q[ln];
        r.moved_count = (moved > 31) ? CNT_MAX : 5'(moved);
        r.dropped_count = (dropped > 31) ? CNT_MAX : 5'(dropped);
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_word_t w;
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) begin
                open_q[i] = 1'b1;
                len_q[i] = 0;
            end
            want_q.delete();
            fail_count = 0;
            result_count = 0;
            drop_events = 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (want_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    w = want_q.pop_front();
                    check_field("status", w.status, m_word.status);
                    check_field("served_tag", w.served_tag, m_word.served_tag);
                    check_field("served_priority", w.served_priority,
                                m_word.served_priority);
                    check_field("served_items", w.served_items, m_word.served_items);
                    check_field("lane_now_open", w.lane_now_open, m_word.lane_now_open);
                    check_field("moved_count", w.moved_count, m_word.moved_count);
                    check_field("dropped_count", w.dropped_count, m_word.dropped_count);
                end
            end
            if (s_valid && s_ready) begin
                w = lane_outcome(s_word);
                if (w.dropped_count != 0) drop_events++;
                want_q.push_back(w);
            end
        end
    end
endmodule

### tb/tb_multi_lane_priority_queue_rebalance_unit.sv
// testbench top: command stimulus, receiver stalls and final verdict
module tb_multi_lane_priority_queue_rebalance_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mlpq_pkg::*;

    localparam int LANES = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int RAND_WORDS = 1850;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    int  fail_count, pending, result_count, drop_events;
    int  words_sent = 0;
    bit  calm = 0;       // no idling on either side while set
    int  stall_left = 0;

    multi_lane_priority_queue_rebalance_unit #(
        .LANES(LANES), .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    mlpq_checker #(.LANES(LANES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word),
        .fail_count(fail_count), .pending(pending),
        .result_count(result_count), .drop_events(drop_events)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if (calm) return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7:       return $urandom_range(1, 3);
            8:             return $urandom_range(4, 12);
            default:       return $urandom_range(20, 80);
        endcase
    endfunction

    // receiver side: random stalls on m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (calm || $urandom_range(0, 3) != 0) begin
            m_ready <= 1'b1;
        end else begin
            stall_left <= gap_len();
            m_ready <= 1'b0;
        end
    end

    // drive one command word; called right after a rising edge
    task automatic send_word(logic [1:0] cmd, logic [2:0] lane, logic [1:0] pr,
                             logic [15:0] tag, logic [7:0] cnt);
        int gap;
        in_word_t w;
        gap = gap_len();
        w.cmd = cmd;
        w.lane = lane;
        w.priority_req = pr;
        w.tag = tag;
        w.item_count = cnt;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        // ready is stable at the falling edge; the word goes at the next rise
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_random(int fill_bias);
        logic [1:0] cmd;
        logic [2:0] lane;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < fill_bias) cmd = CMD_ENQ;
        else if (pick < 88) cmd = CMD_SERVE;
        else if (pick < 97) cmd = CMD_TOGGLE;
        else cmd = CMD_NOP;    // unused code
        // a few lanes past the last one
        lane = ($urandom_range(0, 24) == 0) ? 3'($urandom_range(4, 7))
                                            : 3'($urandom_range(0, LANES - 1));
        send_word(cmd, lane, ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3)),
                  16'($urandom), 8'($urandom));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes and ordering within a lane
        send_word(CMD_ENQ, 3'd0, 2'd3, 16'hFFFF, 8'hFF);
        send_word(CMD_ENQ, 3'd0, 2'd0, 16'h0000, 8'h00);
        send_word(CMD_ENQ, 3'd0, 2'd1, 16'h1234, 8'h05);
        send_word(CMD_ENQ, 3'd0, 2'd1, 16'h1235, 8'h06);
        repeat (5) send_word(CMD_SERVE, 3'd0, 2'd0, 16'h0, 8'h0);   // last hits empty
        // unused code and lanes past the end
        send_word(CMD_NOP, 3'd1, 2'd2, 16'hAAAA, 8'h55);
        send_word(CMD_NOP, 3'd7, 2'd2, 16'h5555, 8'hAA);
        send_word(CMD_ENQ, 3'd4, 2'd1, 16'h1, 8'h1);
        send_word(CMD_SERVE, 3'd7, 2'd1, 16'h1, 8'h1);
        send_word(CMD_TOGGLE, 3'd5, 2'd1, 16'h1, 8'h1);
        // closed lane refuses enqueue and serve
        send_word(CMD_TOGGLE, 3'd1, 2'd1, 16'h0, 8'h0);
        send_word(CMD_ENQ, 3'd1, 2'd2, 16'h77, 8'h7);
        send_word(CMD_SERVE, 3'd1, 2'd2, 16'h0, 8'h0);
        send_word(CMD_TOGGLE, 3'd1, 2'd1, 16'h0, 8'h0);
        // close with entries to move, then down to the last open lane
        send_word(CMD_ENQ, 3'd2, 2'd2, 16'hBEEF, 8'h11);
        send_word(CMD_ENQ, 3'd2, 2'd1, 16'hCAFE, 8'h22);
        send_word(CMD_TOGGLE, 3'd2, 2'd0, 16'h0, 8'h0);
        send_word(CMD_TOGGLE, 3'd0, 2'd0, 16'h0, 8'h0);
        send_word(CMD_TOGGLE, 3'd1, 2'd0, 16'h0, 8'h0);
        send_word(CMD_TOGGLE, 3'd3, 2'd0, 16'h0, 8'h0);   // refused, only one open
        for (int i = 0; i < 3; i++) send_word(CMD_TOGGLE, 3'(i), 2'd0, 16'h0, 8'h0);
        // fill one lane past its depth
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_word(CMD_ENQ, 3'd3, 2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));

        // random phases, alternating filling and draining
        for (int ph = 0; ph < RAND_WORDS / 150; ph++) begin
            calm = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < 150; k++) send_random((ph % 2 == 0) ? 75 : 35);
        end
        s_valid <= 1'b0;
        calm = 0;

        // sample away from the rising edge so the checker has settled
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (200) @(posedge aclk);
        $display("sent %0d command words, checked %0d result words", words_sent, result_count);
        $display("closes that dropped entries: %0d", drop_events);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### files.f
hw/rtl/mlpq_pkg.sv
hw/rtl/mlpq_ram.sv
hw/rtl/mlpq_pick.sv
hw/rtl/multi_lane_priority_queue_rebalance_unit.sv
tb/mlpq_checker.sv
tb/tb_multi_lane_priority_queue_rebalance_unit.sv
